// ===== sv/mssd_pkg.sv =====
// Package for the multiplexed seven-segment scan driver: request codes,
// register indexes, result word types and the glyph and decimal helpers.
// No dependencies.
`default_nettype none

package mssd_pkg;

  // Request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_TIME  = 2'd1,
    REQ_DIGIT = 2'd2,
    REQ_MODE  = 2'd3
  } req_e;

  // Configuration register indexes
  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_REFRESH    = 1'b1;

  localparam logic [6:0]  BRIGHT_RESET  = 7'd30;
  localparam logic [6:0]  BRIGHT_MAX    = 7'd100;
  localparam logic [15:0] REFRESH_RESET = 16'd2083;

  // One word for the shift-register chain
  typedef struct packed {
    logic       last;
    logic [7:0] seg;
    logic [7:0] sel;
  } word_t;

  // Words produced by one beat: num is 0, 1 or 2
  typedef struct packed {
    logic [1:0] num;
    word_t      w0;
    word_t      w1;
  } push_t;

  function automatic logic [7:0] glyph_seg(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'b01111011;
      4'd1:    seg = 8'b00000011;
      4'd2:    seg = 8'b01011110;
      4'd3:    seg = 8'b01001111;
      4'd4:    seg = 8'b00100111;
      4'd5:    seg = 8'b01101101;
      4'd6:    seg = 8'b01111101;
      4'd7:    seg = 8'b01000011;
      4'd8:    seg = 8'b01111111;
      4'd9:    seg = 8'b01101111;
      4'd11:   seg = 8'b10000000;
      default: seg = 8'b00000000;  // blank and unused codes
    endcase
    return seg;
  endfunction

  // Tens digit of a 6-bit value: x*205 >> 11 is exact below 64
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [13:0] prod;
    prod = {8'b0, v} * 14'd205;
    return {1'b0, prod[13:11]};
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] t;
    logic [5:0] t10;
    logic [5:0] r;
    t   = {2'b0, tens_of(v)};
    t10 = (t << 3) + (t << 1);
    r   = v - t10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/mux_seven_segment_scan_driver.sv =====
// Scan driver for a multiplexed seven-segment display behind two chained
// shift registers. Depends on mssd_pkg and mssd_out_queue.
//
// Use:
//   Input stream (s_axis_*): one beat per request. tuser is the request kind
//   (tick, time update, digit write, set mode); tdata carries the fields.
//   Ticks are microsecond strobes; each may yield zero, one or two words.
//   Output stream (m_axis_*): one beat per word for the shift chain, select
//   byte then segment byte; tlast marks the last word of a tick.
//   Config port: cfg_we_i writes register cfg_idx_i (0 brightness percent,
//   1 refresh period in ticks). Write only while the block is idle.
// Timing:
//   A beat is registered at the input stage, processed from there and its
//   words land in a two-entry output queue, whose count register drives
//   m_axis_tvalid. One request per cycle is taken as long as the output
//   queue has room for the words of the request being processed;
//   the queue depth sets that limit.
// Reset: frame shows 8,8,8,0, scan at digit 0, counters clear, time mode on,
//   brightness 30, refresh period 2083. No clearing pass is needed.
// Stall: when the receiver holds tready low the queue fills, the staged
//   request waits, and s_axis_tready drops until words drain.
`default_nettype none

module mux_seven_segment_scan_driver #(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] digit_index, [5:2] glyph_code, [11:6] minutes, [17:12] seconds,
  // [18] show_time, [23:19] zero
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] digit_select, [15:8] segment_bits
  output logic             m_axis_tlast,   // last_of_tick
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import mssd_pkg::*;

  localparam int DIG_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int TIME_DIGITS = (NUM_DIGITS < 4) ? NUM_DIGITS : 4;

  // Config registers
  logic [6:0]  bright_q;
  logic [15:0] refresh_q;

  // Input stage
  logic        in_v_q, in_v_d;
  req_e        req_q;
  logic [18:0] in_data_q;

  // Display state
  logic [3:0]       fb_q [NUM_DIGITS];
  logic [3:0]       fb_d [NUM_DIGITS];
  logic [DIG_W-1:0] scan_q, scan_d;
  logic [15:0]      period_q, period_d;
  logic [10:0]      blank_q, blank_d;
  logic             pend_q, pend_d;
  logic             tmode_q, tmode_d;

  // Field views of the staged beat
  logic [1:0] f_idx;
  logic [3:0] f_glyph;
  logic [5:0] f_min;
  logic [5:0] f_sec;
  logic       f_show;
  logic [3:0] tdig [4];

  logic [15:0] cnt_inc;
  logic [15:0] period_eff;
  logic [6:0]  bright_c;
  logic [10:0] on_time;
  logic [10:0] blank_dec;
  logic        scan_hit;
  logic [1:0]  n_res;
  logic [1:0]  free;
  logic        advance;
  word_t       scan_w, blank_w;
  push_t       push;

  assign f_idx   = in_data_q[1:0];
  assign f_glyph = in_data_q[5:2];
  assign f_min   = in_data_q[11:6];
  assign f_sec   = in_data_q[17:12];
  assign f_show  = in_data_q[18];

  assign tdig[0] = tens_of(f_min);
  assign tdig[1] = ones_of(f_min);
  assign tdig[2] = tens_of(f_sec);
  assign tdig[3] = ones_of(f_sec);

  // Tick datapath: period compare, on-time = brightness * 20
  assign cnt_inc    = period_q + 16'd1;
  assign period_eff = (refresh_q == 16'd0) ? 16'd1 : refresh_q;
  assign scan_hit   = (cnt_inc >= period_eff);
  assign bright_c   = (bright_q > BRIGHT_MAX) ? BRIGHT_MAX : bright_q;
  assign on_time    = ({4'b0, bright_c} << 4) + ({4'b0, bright_c} << 2);
  assign blank_dec  = (blank_q != 11'd0) ? (blank_q - 11'd1) : 11'd0;

  always_comb begin
    scan_w.sel  = 8'd1 << scan_q;
    scan_w.seg  = glyph_seg(fb_q[scan_q]);
    scan_w.last = (on_time != 11'd0);
    blank_w     = '{last: 1'b1, seg: 8'd0, sel: 8'd0};
  end

  // Words this beat would produce
  always_comb begin
    n_res = 2'd0;
    push  = '0;
    if (req_q == REQ_TICK) begin
      if (scan_hit) begin
        n_res   = (on_time == 11'd0) ? 2'd2 : 2'd1;
        push.w0 = scan_w;
        push.w1 = blank_w;
      end else if (pend_q && (blank_dec == 11'd0)) begin
        n_res   = 2'd1;
        push.w0 = blank_w;
      end
    end
    advance  = in_v_q && (n_res <= free);
    push.num = advance ? n_res : 2'd0;
  end

  assign s_axis_tready = !in_v_q || advance;

  // Next state, applied when the staged beat advances
  always_comb begin
    in_v_d   = in_v_q;
    fb_d     = fb_q;
    scan_d   = scan_q;
    period_d = period_q;
    blank_d  = blank_q;
    pend_d   = pend_q;
    tmode_d  = tmode_q;
    if (advance) begin
      in_v_d = 1'b0;
      case (req_q)
        REQ_TICK: begin
          period_d = cnt_inc;
          if (scan_hit) begin
            period_d = 16'd0;
            scan_d   = (int'(scan_q) == NUM_DIGITS - 1) ? '0 : scan_q + 1'b1;
            blank_d  = on_time;
            pend_d   = (on_time != 11'd0);
          end else if (pend_q) begin
            blank_d = blank_dec;
            if (blank_dec == 11'd0) pend_d = 1'b0;
          end
        end
        REQ_TIME: begin
          if (tmode_q) begin
            for (int i = 0; i < TIME_DIGITS; i++) fb_d[i] = tdig[i];
          end
        end
        REQ_DIGIT: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            if (int'(f_idx) == i) fb_d[i] = f_glyph;
          end
        end
        REQ_MODE: tmode_d = f_show;
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) in_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q  <= BRIGHT_RESET;
      refresh_q <= REFRESH_RESET;
      in_v_q    <= 1'b0;
      scan_q    <= '0;
      period_q  <= 16'd0;
      blank_q   <= 11'd0;
      pend_q    <= 1'b0;
      tmode_q   <= 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) fb_q[i] <= (i == 3) ? 4'd0 : 4'd8;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BRIGHTNESS: bright_q  <= cfg_data_i[6:0];
          CFG_REFRESH:    refresh_q <= cfg_data_i;
          default: ;
        endcase
      end
      in_v_q   <= in_v_d;
      scan_q   <= scan_d;
      period_q <= period_d;
      blank_q  <= blank_d;
      pend_q   <= pend_d;
      tmode_q  <= tmode_d;
      fb_q     <= fb_d;
    end
  end

  // Input payload register, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q     <= req_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata[18:0];
    end
  end

  mssd_out_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(scan_q) < NUM_DIGITS)
    else $error("scan pointer out of range");

  a_pend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (blank_q != 11'd0))
    else $error("blank pending with zero count");

  a_blank_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blank_q <= 11'd2000)
    else $error("blank count above maximum on-time");

  a_blank_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[7:0] == 8'd0)) |-> m_axis_tlast)
    else $error("blank word not marked last of tick");

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> (n_res <= free))
    else $error("queue overrun");
`endif

endmodule

`default_nettype wire

// ===== sv/mssd_out_queue.sv =====
// Two-entry result queue for the scan driver; takes up to two words per beat
// and drives the master stream. Depends on mssd_pkg.
`default_nettype none

module mssd_out_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mssd_pkg::push_t push_i,
  output logic [1:0]           free_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [7:0] digit_select, [15:8] segment_bits
  output logic                 m_axis_tlast    // last_of_tick
);
  import mssd_pkg::*;

  word_t      q0_q, q0_d, q1_q, q1_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  always_comb begin
    pop  = (cnt_q != 2'd0) && m_axis_tready;
    base = cnt_q - {1'b0, pop};
    q0_d = pop ? q1_q : q0_q;
    q1_d = q1_q;
    case (base)
      2'd0: begin
        if (push_i.num != 2'd0) q0_d = push_i.w0;
        q1_d = push_i.w1;
      end
      2'd1: begin
        if (push_i.num != 2'd0) q1_d = push_i.w0;
      end
      default: ;
    endcase
    cnt_d = base + push_i.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  assign free_o        = 2'd2 - cnt_q;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {q0_q.seg, q0_q.sel};
  assign m_axis_tlast  = q0_q.last;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mux_seven_segment_scan_driver: random stream traffic
// on both sides, expected shift-chain words worked out by an in-bench scan model.
// Depends on mssd_pkg for request codes and register indexes.

module tb;
  import mssd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_PHASES = 9;
  localparam int          PHASE_ITEMS = 94;

  // Segment pattern per glyph code, code 0 in the low byte; codes 10, 12-15 are dark
  localparam logic [127:0] GLYPH_SEGS = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h6F, 8'h7F,
    8'h43, 8'h7D, 8'h6D, 8'h27, 8'h4F, 8'h5E, 8'h03, 8'h7B
  };

  typedef struct packed {
    logic       last;
    logic [7:0] seg;
    logic [7:0] sel;
  } chain_word_t;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  // Scan model state, mirrors the block
  logic [3:0]  frame_glyph [4];
  logic [1:0]  scan_pos;
  logic [15:0] period_cnt;
  logic [10:0] blank_cnt;
  logic        blank_armed;
  logic        time_shown;
  logic [6:0]  bright_reg;
  logic [15:0] refresh_reg;

  chain_word_t chain_words_q[$];  // words still owed by the block

  int          errors = 0;
  int unsigned cycle_count = 0;
  bit          sender_eager = 1'b0;  // no gaps between input beats
  bit          sink_eager = 1'b0;    // no stalls on the output side
  int          sink_stall = 0;

  mux_seven_segment_scan_driver #(
    .NUM_DIGITS(4)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: after each accepted word, hold tready low for a randomly drawn
  // stall, or not at all while sink_eager is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sink_stall = sink_eager ? 0 : $urandom_range(0, 12);
        if (sink_stall > 0) begin
          m_axis_tready <= 1'b0;
          sink_stall = sink_stall - 1;
        end
      end else if (!m_axis_tready) begin
        if (sink_stall == 0) m_axis_tready <= 1'b1;
        else sink_stall = sink_stall - 1;
      end
    end
  end

  // Word checker: every beat on the master side against the oldest owed word
  always @(posedge clk_i) begin : check_word
    chain_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (chain_words_q.size() == 0) begin
        errors++;
        $display("%0t: expected no word, got sel=%h seg=%h last=%b", $time,
                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
      end else begin
        want = chain_words_q.pop_front();
        if (m_axis_tdata[7:0] !== want.sel) begin
          errors++;
          $display("%0t: digit_select expected %h got %h", $time, want.sel,
                   m_axis_tdata[7:0]);
        end
        if (m_axis_tdata[15:8] !== want.seg) begin
          errors++;
          $display("%0t: segment_bits expected %h got %h", $time, want.seg,
                   m_axis_tdata[15:8]);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last_of_tick expected %b got %b", $time, want.last,
                   m_axis_tlast);
        end
      end
    end
  end

  // Model of one accepted request; queues the words it makes the block latch
  function automatic void advance_scan(input req_e kind, input logic [23:0] d);
    logic [5:0]  mins;
    logic [5:0]  secs;
    int unsigned period;
    int unsigned on_us;
    logic [1:0]  cur;
    chain_word_t w;
    mins = d[11:6];
    secs = d[17:12];
    case (kind)
      REQ_TIME: begin
        // ignored while time mode is off; tens show 6 for values above 59
        if (time_shown) begin
          frame_glyph[0] = 4'((mins / 10) % 10);
          frame_glyph[1] = 4'(mins % 10);
          frame_glyph[2] = 4'((secs / 10) % 10);
          frame_glyph[3] = 4'(secs % 10);
        end
      end
      REQ_DIGIT: frame_glyph[d[1:0]] = d[5:2];
      REQ_MODE:  time_shown = d[18];
      default: begin
        period = (refresh_reg == 16'd0) ? 1 : refresh_reg;  // zero period acts as 1
        period_cnt = period_cnt + 16'd1;
        if (period_cnt >= period) begin
          cur = scan_pos;
          on_us = ((bright_reg > 7'd100) ? 100 : bright_reg) * 20;
          period_cnt = '0;
          w.sel = 8'(1 << cur);
          w.seg = GLYPH_SEGS[frame_glyph[cur]*8 +: 8];
          w.last = (on_us != 0);
          chain_words_q.push_back(w);
          scan_pos = cur + 2'd1;
          if (on_us == 0) begin
            // zero on-time: blank word on the same tick
            blank_armed = 1'b0;
            blank_cnt = '0;
            chain_words_q.push_back('{last: 1'b1, seg: 8'h00, sel: 8'h00});
          end else begin
            // a new scan rearms the timer; an expiring blank is dropped
            blank_cnt = 11'(on_us);
            blank_armed = 1'b1;
          end
        end else if (blank_armed) begin
          if (blank_cnt > 0) blank_cnt = blank_cnt - 11'd1;
          if (blank_cnt == 0) begin
            blank_armed = 1'b0;
            chain_words_q.push_back('{last: 1'b1, seg: 8'h00, sel: 8'h00});
          end
        end
      end
    endcase
  endfunction

  // One input beat: random gap, then hold until accepted
  task automatic send_req(input req_e kind, input logic [23:0] d);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_scan(kind, d);
  endtask

  // Field packing: [1:0] digit, [5:2] glyph, [11:6] min, [17:12] sec, [18] show
  function automatic logic [23:0] req_fields(input logic [1:0] idx, input logic [3:0] glyph,
                                             input logic [5:0] mins, input logic [5:0] secs,
                                             input logic show);
    return {5'b0, show, secs, mins, glyph, idx};
  endfunction

  task automatic tick_burst(input int count);
    repeat (count) send_req(REQ_TICK, req_fields('0, '0, '0, '0, 1'b0));
  endtask

  // Stop sending and let every owed word come out
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (chain_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers back to back; block must be idle
  task automatic set_config(input logic [6:0] bright, input logic [15:0] period);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_BRIGHTNESS;
    cfg_data_i <= {9'b0, bright};
    @(posedge clk_i);
    cfg_idx_i <= CFG_REFRESH;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bright_reg = bright;
    refresh_reg = period;
    @(posedge clk_i);
  endtask

  // Frame after reset, time and digit writes, mode gating, register extremes
  task automatic test_directed();
    set_config(7'd0, 16'd0);  // scan and blank on every tick
    tick_burst(4);            // shows the reset frame 8,8,8,0
    send_req(REQ_TIME, req_fields(2'd1, 4'd2, 6'd63, 6'd63, 1'b0));
    send_req(REQ_DIGIT, req_fields(2'd3, 4'd15, 6'd0, 6'd0, 1'b0));
    send_req(REQ_DIGIT, req_fields(2'd0, 4'd11, 6'd63, 6'd63, 1'b1));
    send_req(REQ_DIGIT, req_fields(2'd1, 4'd10, 6'd0, 6'd0, 1'b0));
    send_req(REQ_DIGIT, req_fields(2'd2, 4'd0, 6'd0, 6'd0, 1'b0));
    tick_burst(4);
    send_req(REQ_MODE, req_fields(2'd3, 4'd15, 6'd63, 6'd63, 1'b0));
    send_req(REQ_TIME, req_fields(2'd0, 4'd0, 6'd45, 6'd27, 1'b0));  // dropped
    send_req(REQ_MODE, req_fields(2'd0, 4'd0, 6'd0, 6'd0, 1'b1));
    send_req(REQ_TIME, req_fields(2'd0, 4'd0, 6'd0, 6'd0, 1'b1));
    tick_burst(2);
    wait_quiet();
    set_config(7'd127, 16'd65535);  // no scan within a few ticks
    tick_burst(2);
    wait_quiet();
    set_config(7'd100, 16'd1);  // scan every tick; pending blank keeps being dropped
    tick_burst(3);
    wait_quiet();
  endtask

  // Brightness above 100 must clamp to a 2000 us on-time. At 103 an unclamped
  // on-time wraps in 11 bits to 12 us, which would let a blank word out
  // before the next scan; clamped, every blank is rearmed and dropped.
  task automatic test_on_time_clamp();
    sender_eager = 1'b1;
    sink_eager = 1'b1;
    set_config(7'd103, 16'd40);
    tick_burst(80);
    wait_quiet();
    sender_eager = 1'b0;
    sink_eager = 1'b0;
  endtask

  // Mixed requests with random content over several register settings
  task automatic test_random_traffic();
    int          r;
    logic [6:0]  bright;
    logic [15:0] period;
    req_e        kind;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        bright = 7'd1;    // scan lands on the tick the blank would expire
        period = 16'd20;
      end else begin
        case ($urandom_range(0, 5))
          0:       bright = 7'd0;
          1, 2:    bright = 7'd1;
          3:       bright = 7'd2;
          4:       bright = 7'($urandom_range(3, 127));
          default: bright = 7'd3;
        endcase
        if (bright > 7'd3) period = 16'($urandom_range(0, 12));
        else period = 16'($urandom_range(0, 20 * bright + 30));
      end
      sender_eager = ($urandom_range(0, 3) == 0);
      sink_eager = ($urandom_range(0, 3) == 0);
      set_config(bright, period);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 68) kind = REQ_TICK;
        else if (r < 80) kind = REQ_TIME;
        else if (r < 93) kind = REQ_DIGIT;
        else kind = REQ_MODE;
        send_req(kind, req_fields(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                  6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                  ($urandom_range(0, 3) != 0)));
      end
      wait_quiet();  // full drain before the next register change
    end
    sender_eager = 1'b0;
    sink_eager = 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= REQ_TICK;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_BRIGHTNESS;
    cfg_data_i <= '0;
    // model reset state
    frame_glyph = '{4'd8, 4'd8, 4'd8, 4'd0};
    scan_pos = '0;
    period_cnt = '0;
    blank_cnt = '0;
    blank_armed = 1'b0;
    time_shown = 1'b1;
    bright_reg = BRIGHT_RESET;
    refresh_reg = REFRESH_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_on_time_clamp();
    test_random_traffic();

    wait_quiet();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
